### sv/pprk_pkg.sv
`default_nettype none

package pprk_pkg;

    // Fixed field widths of the stream payload
    localparam int INDEX_BITS = 32;
    localparam int AMP_BITS   = 32;
    localparam int COEF_BITS  = 32;
    localparam int PROD_BITS  = AMP_BITS + COEF_BITS;
    // Q1.30 products: drop 30 fraction bits after rounding
    localparam int FRAC_BITS  = 30;
    localparam int RND_BITS   = PROD_BITS - FRAC_BITS;
    localparam int SUM_BITS   = RND_BITS + 1;

    localparam int IN_DATA_BITS  = INDEX_BITS + 4 * AMP_BITS;
    localparam int OUT_DATA_BITS = INDEX_BITS + 4 * AMP_BITS;

    // Register indexes on the configuration port
    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_X_MASK    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_Z_MASK    = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COS_THETA = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SIN_THETA = 2'd3;

    // Reset value of cos_theta: 1.0 in Q1.30
    localparam logic [COEF_BITS-1:0] COS_ONE = 32'h4000_0000;

    // Quarter-turn phase, w(z) = i^(z+1)
    typedef logic [1:0] phase_t;
    localparam phase_t PH_PLUS_I  = 2'd0;
    localparam phase_t PH_MINUS_1 = 2'd1;
    localparam phase_t PH_MINUS_I = 2'd2;
    localparam phase_t PH_PLUS_1  = 2'd3;

    typedef logic signed [AMP_BITS-1:0]  amp_t;
    typedef logic signed [COEF_BITS-1:0] coef_t;

    // Load strobes for the arithmetic stages
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } pprk_adv_t;

endpackage

`default_nettype wire

### sv/pprk_rotate.sv
`default_nettype none

module pprk_rotate
    import pprk_pkg::*;
(
    input  wire logic      clk,
    input  wire pprk_adv_t adv,
    input  wire coef_t     cos_c,
    input  wire coef_t     sin_s,
    input  wire amp_t      a_re,
    input  wire amp_t      a_im,
    input  wire amp_t      b_re,
    input  wire amp_t      b_im,
    input  wire phase_t    phase,
    output amp_t           o_re,
    output amp_t           o_im
);

    localparam logic signed [PROD_BITS-1:0] RND_HALF = PROD_BITS'(64'sd1 <<< (FRAC_BITS - 1));
    localparam logic signed [SUM_BITS-1:0]  SAT_HI   =
        SUM_BITS'((65'sd1 <<< (AMP_BITS - 1)) - 65'sd1);
    localparam logic signed [SUM_BITS-1:0]  SAT_LO   = -SAT_HI - SUM_BITS'(1);

    logic signed [PROD_BITS-1:0] ca_re_reg, ca_im_reg, sb_re_reg, sb_im_reg;
    phase_t                      ph2_reg, ph3_reg;
    logic signed [RND_BITS-1:0]  ra_re_reg, ra_im_reg, rb_re_reg, rb_im_reg;
    amp_t                        o_re_reg, o_im_reg;

    logic signed [PROD_BITS-1:0] ra_re_full, ra_im_full, rb_re_full, rb_im_full;
    logic signed [SUM_BITS-1:0]  xa_re, xa_im, xb_re, xb_im;
    logic signed [SUM_BITS-1:0]  sum_re, sum_im;
    amp_t                        o_re_next, o_im_next;

    // Stage 2: full products
    always_ff @(posedge clk)
    begin
        if (adv.s2)
        begin
            ca_re_reg <= PROD_BITS'(cos_c * a_re);
            ca_im_reg <= PROD_BITS'(cos_c * a_im);
            sb_re_reg <= PROD_BITS'(sin_s * b_re);
            sb_im_reg <= PROD_BITS'(sin_s * b_im);
            ph2_reg   <= phase;
        end
    end

    // Round half up, then floor by the fraction width
    always_comb
    begin
        ra_re_full = ca_re_reg + RND_HALF;
        ra_im_full = ca_im_reg + RND_HALF;
        rb_re_full = sb_re_reg + RND_HALF;
        rb_im_full = sb_im_reg + RND_HALF;
    end

    // Stage 3: rounded terms
    always_ff @(posedge clk)
    begin
        if (adv.s3)
        begin
            ra_re_reg <= ra_re_full[PROD_BITS-1:FRAC_BITS];
            ra_im_reg <= ra_im_full[PROD_BITS-1:FRAC_BITS];
            rb_re_reg <= rb_re_full[PROD_BITS-1:FRAC_BITS];
            rb_im_reg <= rb_im_full[PROD_BITS-1:FRAC_BITS];
            ph3_reg   <= ph2_reg;
        end
    end

    // Apply the phase sign and add exactly
    always_comb
    begin
        xa_re = SUM_BITS'(ra_re_reg);
        xa_im = SUM_BITS'(ra_im_reg);
        xb_re = SUM_BITS'(rb_re_reg);
        xb_im = SUM_BITS'(rb_im_reg);
        case (ph3_reg)
            PH_PLUS_I:
            begin
                sum_re = xa_re - xb_im;
                sum_im = xa_im + xb_re;
            end
            PH_MINUS_1:
            begin
                sum_re = xa_re - xb_re;
                sum_im = xa_im - xb_im;
            end
            PH_MINUS_I:
            begin
                sum_re = xa_re + xb_im;
                sum_im = xa_im - xb_re;
            end
            default:
            begin
                sum_re = xa_re + xb_re;
                sum_im = xa_im + xb_im;
            end
        endcase
    end

    // Saturate to the amplitude range
    always_comb
    begin
        if (sum_re > SAT_HI)
            o_re_next = SAT_HI[AMP_BITS-1:0];
        else if (sum_re < SAT_LO)
            o_re_next = SAT_LO[AMP_BITS-1:0];
        else
            o_re_next = sum_re[AMP_BITS-1:0];

        if (sum_im > SAT_HI)
            o_im_next = SAT_HI[AMP_BITS-1:0];
        else if (sum_im < SAT_LO)
            o_im_next = SAT_LO[AMP_BITS-1:0];
        else
            o_im_next = sum_im[AMP_BITS-1:0];
    end

    // Stage 4: output register
    always_ff @(posedge clk)
    begin
        if (adv.s4)
        begin
            o_re_reg <= o_re_next;
            o_im_reg <= o_im_next;
        end
    end

    assign o_re = o_re_reg;
    assign o_im = o_im_reg;

endmodule

`default_nettype wire

### sv/pauli_rotation_pair_kernel.sv
`default_nettype none

// Channel   Dir  Bits  Fields (low bit up)
// s_axis    in   160   index_i, amp_i_re, amp_i_im, amp_j_re, amp_j_im
// m_axis    out  160   index_j, new_i_re, new_i_im, new_j_re, new_j_im; tuser: pair_duplicate
// cfg       in    32   cfg_index 0..3: x_mask, z_mask, cos_theta, sin_theta
//
// Four register stages: partner index and phases, products, rounding,
// signed add with saturation into the output register.
// One request per cycle while m_axis takes results; m_axis_tvalid is the stage-four valid bit.
// Each stage loads when it is empty or the stage after it moves, so a stall
// at m_axis fills bubbles first and only then drops s_axis_tready.
// rst_n clears the valid bits and sets the coefficients to cos = 1.0, sin = 0.

module pauli_rotation_pair_kernel
    import pprk_pkg::*;
#(
    parameter int QUBIT_COUNT = 32
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    // index_i, amp_i_re, amp_i_im, amp_j_re, amp_j_im
    input  wire logic [IN_DATA_BITS-1:0]   s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    // index_j, new_i_re, new_i_im, new_j_re, new_j_im
    output logic [OUT_DATA_BITS-1:0]       m_axis_tdata,
    // pair_duplicate
    output logic [0:0]                     m_axis_tuser,
    input  wire logic                      cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [COEF_BITS-1:0]      cfg_data
);

    localparam int IDX_BITS = (QUBIT_COUNT < INDEX_BITS) ? QUBIT_COUNT : INDEX_BITS;
    localparam logic [INDEX_BITS:0] QMASK_WIDE =
        ((INDEX_BITS+1)'(1) << IDX_BITS) - (INDEX_BITS+1)'(1);
    localparam logic [INDEX_BITS-1:0] QMASK = QMASK_WIDE[INDEX_BITS-1:0];

    // Configuration registers
    logic [INDEX_BITS-1:0] x_mask_reg, z_mask_reg;
    coef_t                 cos_reg, sin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_mask_reg <= '0;
            z_mask_reg <= '0;
            cos_reg    <= COS_ONE;
            sin_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_X_MASK:    x_mask_reg <= cfg_data;
                REG_Z_MASK:    z_mask_reg <= cfg_data;
                REG_COS_THETA: cos_reg    <= cfg_data;
                REG_SIN_THETA: sin_reg    <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Stage load enables, chained back from the output
    logic      v1_reg, v2_reg, v3_reg, v4_reg;
    logic      ld1, ld2, ld3, ld4;
    pprk_adv_t adv;

    always_comb
    begin
        ld4    = !v4_reg || m_axis_tready;
        ld3    = !v3_reg || ld4;
        ld2    = !v2_reg || ld3;
        ld1    = !v1_reg || ld2;
        adv.s2 = ld2;
        adv.s3 = ld3;
        adv.s4 = ld4;
    end

    assign s_axis_tready = ld1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (ld1)
                v1_reg <= s_axis_tvalid;
            if (ld2)
                v2_reg <= v1_reg;
            if (ld3)
                v3_reg <= v2_reg;
            if (ld4)
                v4_reg <= v3_reg;
        end
    end

    // Stage 1: partner index, duplicate flag and quarter-turn phases
    logic [INDEX_BITS-1:0] xm, zm, idx_i, idx_j;
    phase_t                ys, phase_i_next, phase_j_next;
    logic                  par_i, par_j;

    always_comb
    begin
        xm    = x_mask_reg & QMASK;
        zm    = z_mask_reg & QMASK;
        idx_i = s_axis_tdata[INDEX_BITS-1:0] & QMASK;
        idx_j = idx_i ^ xm;
        ys    = 2'($countones(xm & zm));
        par_i = ^(idx_i & zm);
        par_j = ^(idx_j & zm);
        // Adding twice a parity only flips the upper phase bit
        phase_i_next = {ys[1] ^ par_j, ys[0]};
        phase_j_next = {ys[1] ^ par_i, ys[0]};
    end

    logic [INDEX_BITS-1:0] idx_j1_reg, idx_j2_reg, idx_j3_reg, idx_j4_reg;
    logic                  dup1_reg, dup2_reg, dup3_reg, dup4_reg;
    phase_t                phase_i_reg, phase_j_reg;
    amp_t                  ai_re_reg, ai_im_reg, aj_re_reg, aj_im_reg;

    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            idx_j1_reg  <= idx_j;
            dup1_reg    <= (idx_j < idx_i);
            phase_i_reg <= phase_i_next;
            phase_j_reg <= phase_j_next;
            ai_re_reg   <= s_axis_tdata[INDEX_BITS +: AMP_BITS];
            ai_im_reg   <= s_axis_tdata[INDEX_BITS + AMP_BITS +: AMP_BITS];
            aj_re_reg   <= s_axis_tdata[INDEX_BITS + 2*AMP_BITS +: AMP_BITS];
            aj_im_reg   <= s_axis_tdata[INDEX_BITS + 3*AMP_BITS +: AMP_BITS];
        end
    end

    // Carry index and flag alongside the arithmetic
    always_ff @(posedge clk)
    begin
        if (ld2)
        begin
            idx_j2_reg <= idx_j1_reg;
            dup2_reg   <= dup1_reg;
        end
        if (ld3)
        begin
            idx_j3_reg <= idx_j2_reg;
            dup3_reg   <= dup2_reg;
        end
        if (ld4)
        begin
            idx_j4_reg <= idx_j3_reg;
            dup4_reg   <= dup3_reg;
        end
    end

    // Rotation of both amplitudes of the pair
    amp_t new_i_re, new_i_im, new_j_re, new_j_im;

    pprk_rotate u_rot_i (
        .clk   (clk),
        .adv   (adv),
        .cos_c (cos_reg),
        .sin_s (sin_reg),
        .a_re  (ai_re_reg),
        .a_im  (ai_im_reg),
        .b_re  (aj_re_reg),
        .b_im  (aj_im_reg),
        .phase (phase_i_reg),
        .o_re  (new_i_re),
        .o_im  (new_i_im)
    );

    pprk_rotate u_rot_j (
        .clk   (clk),
        .adv   (adv),
        .cos_c (cos_reg),
        .sin_s (sin_reg),
        .a_re  (aj_re_reg),
        .a_im  (aj_im_reg),
        .b_re  (ai_re_reg),
        .b_im  (ai_im_reg),
        .phase (phase_j_reg),
        .o_re  (new_j_re),
        .o_im  (new_j_im)
    );

    assign m_axis_tvalid   = v4_reg;
    assign m_axis_tdata    = {new_j_im, new_j_re, new_i_im, new_i_re, idx_j4_reg};
    assign m_axis_tuser[0] = dup4_reg;

`ifndef SYNTHESIS
    // An accepted request lands in stage one
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> v1_reg)
        else $error("accepted request missing from stage one");

    // A stalled stage keeps its item
    a_stage1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && !ld2 |=> v1_reg)
        else $error("stage one item lost under stall");

    a_stage2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && !ld3 |=> v2_reg && $stable(idx_j2_reg))
        else $error("stage two item lost under stall");

    // A bubble in the pipe never blocks the input
    a_bubble_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !v1_reg || !v2_reg || !v3_reg || !v4_reg |-> s_axis_tready)
        else $error("input stalled with a free stage");
`endif

endmodule

`default_nettype wire

### sim/pprk_pair_checker.sv
module pprk_pair_checker
    import pprk_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    input  logic                      s_axis_tready,
    // index_i, amp_i_re, amp_i_im, amp_j_re, amp_j_im
    input  logic [IN_DATA_BITS-1:0]   s_axis_tdata,
    input  logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // index_j, new_i_re, new_i_im, new_j_re, new_j_im
    input  logic [OUT_DATA_BITS-1:0]  m_axis_tdata,
    // pair_duplicate
    input  logic [0:0]                m_axis_tuser,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [COEF_BITS-1:0]      cfg_data,
    output int                        mismatches,
    output int                        outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint AMP_HI = (longint'(1) <<< (AMP_BITS - 1)) - 1;
    localparam longint AMP_LO = -AMP_HI - 1;
    localparam int     SHOWN_MISMATCHES = 10;

    typedef struct packed {
        amp_t re;
        amp_t im;
    } cplx_t;

    // Same layout as {m_axis_tuser, m_axis_tdata}
    typedef struct packed {
        logic                  dup;
        amp_t                  j_im;
        amp_t                  j_re;
        amp_t                  i_im;
        amp_t                  i_re;
        logic [INDEX_BITS-1:0] idx_j;
    } rotated_pair_t;

    // Local copy of the rotation registers
    logic [INDEX_BITS-1:0] rot_x   = '0;
    logic [INDEX_BITS-1:0] rot_z   = '0;
    coef_t                 rot_cos = COS_ONE;
    coef_t                 rot_sin = '0;

    rotated_pair_t pending_pairs[$];
    int            fail_total = 0;

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
    end

    // Q1.30 product, round half up (floor after adding half an LSB)
    function automatic longint q30_product(coef_t k, amp_t v);
        longint p;
        p = longint'(k) * longint'(v) + (longint'(1) <<< (FRAC_BITS - 1));
        return p >>> FRAC_BITS;
    endfunction

    function automatic amp_t clamp_amp(longint v);
        if (v > AMP_HI)
            return amp_t'(AMP_HI);
        if (v < AMP_LO)
            return amp_t'(AMP_LO);
        return amp_t'(v);
    endfunction

    // c*a + s*w(ph)*b with w = i^(ph+1)
    function automatic cplx_t turn_amp(phase_t ph, amp_t a_re, amp_t a_im,
                                       amp_t b_re, amp_t b_im);
        longint ca_re, ca_im, sb_re, sb_im, re, im;
        cplx_t  r;
        ca_re = q30_product(rot_cos, a_re);
        ca_im = q30_product(rot_cos, a_im);
        sb_re = q30_product(rot_sin, b_re);
        sb_im = q30_product(rot_sin, b_im);
        re = 0;
        im = 0;
        case (ph)
            PH_PLUS_I:
            begin
                re = ca_re - sb_im;
                im = ca_im + sb_re;
            end
            PH_MINUS_1:
            begin
                re = ca_re - sb_re;
                im = ca_im - sb_im;
            end
            PH_MINUS_I:
            begin
                re = ca_re + sb_im;
                im = ca_im - sb_re;
            end
            PH_PLUS_1:
            begin
                re = ca_re + sb_re;
                im = ca_im + sb_im;
            end
            default: ;
        endcase
        r.re = clamp_amp(re);
        r.im = clamp_amp(im);
        return r;
    endfunction

    function automatic rotated_pair_t rotate_pair(logic [IN_DATA_BITS-1:0] req);
        logic [INDEX_BITS-1:0] idx_i, idx_j;
        amp_t                  ai_re, ai_im, aj_re, aj_im;
        int                    y_count;
        phase_t                ph_i, ph_j;
        cplx_t                 new_i, new_j;
        rotated_pair_t         r;
        idx_i = req[INDEX_BITS-1:0];
        ai_re = req[INDEX_BITS + 0*AMP_BITS +: AMP_BITS];
        ai_im = req[INDEX_BITS + 1*AMP_BITS +: AMP_BITS];
        aj_re = req[INDEX_BITS + 2*AMP_BITS +: AMP_BITS];
        aj_im = req[INDEX_BITS + 3*AMP_BITS +: AMP_BITS];
        idx_j = idx_i ^ rot_x;
        // each Y factor adds a quarter turn, each Z hit on the index a half
        y_count = $countones(rot_x & rot_z);
        ph_i = phase_t'(y_count + 2 * $countones(idx_j & rot_z));
        ph_j = phase_t'(y_count + 2 * $countones(idx_i & rot_z));
        new_i = turn_amp(ph_i, ai_re, ai_im, aj_re, aj_im);
        new_j = turn_amp(ph_j, aj_re, aj_im, ai_re, ai_im);
        r.idx_j = idx_j;
        r.i_re  = new_i.re;
        r.i_im  = new_i.im;
        r.j_re  = new_j.re;
        r.j_im  = new_j.im;
        r.dup   = (idx_j < idx_i);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rotated_pair_t got, want;
        logic          bad;
        if (!rst_n)
        begin
            rot_x   = '0;
            rot_z   = '0;
            rot_cos = COS_ONE;
            rot_sin = '0;
        end
        else
        begin
            // track register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_X_MASK:    rot_x   = cfg_data;
                    REG_Z_MASK:    rot_z   = cfg_data;
                    REG_COS_THETA: rot_cos = cfg_data;
                    REG_SIN_THETA: rot_sin = cfg_data;
                    default:       ;
                endcase
            end
            // predict each accepted request
            if (s_axis_tvalid && s_axis_tready)
                pending_pairs.push_back(rotate_pair(s_axis_tdata));
            // compare each accepted result with the oldest prediction
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = {m_axis_tuser, m_axis_tdata};
                if (pending_pairs.size() == 0)
                begin
                    if (fail_total < SHOWN_MISMATCHES)
                        $display("%0t: unexpected result, index_j %h", $time, got.idx_j);
                    fail_total++;
                end
                else
                begin
                    want = pending_pairs.pop_front();
                    bad = (got.idx_j !== want.idx_j) || (got.i_re !== want.i_re)
                       || (got.i_im !== want.i_im) || (got.j_re !== want.j_re)
                       || (got.j_im !== want.j_im) || (got.dup !== want.dup);
                    if (bad)
                    begin
                        if (fail_total < SHOWN_MISMATCHES)
                        begin
                            $display("%0t: mismatch want j=%h i=(%h,%h) j=(%h,%h) dup=%b",
                                     $time, want.idx_j, want.i_re, want.i_im,
                                     want.j_re, want.j_im, want.dup);
                            $display("%0t:           got j=%h i=(%h,%h) j=(%h,%h) dup=%b",
                                     $time, got.idx_j, got.i_re, got.i_im,
                                     got.j_re, got.j_im, got.dup);
                        end
                        fail_total++;
                    end
                end
            end
        end
        mismatches  <= fail_total;
        outstanding <= pending_pairs.size();
    end

endmodule

### sim/pauli_rotation_pair_kernel_tb.sv
module pauli_rotation_pair_kernel_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pprk_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 64;
    localparam int DRAIN_CYCLES = 8;
    localparam int SEGMENT_REQS = 130;
    localparam int PRESSURE_REQS = 80;

    localparam logic [INDEX_BITS-1:0] ALL_ONES    = 32'hFFFF_FFFF;
    localparam amp_t                  A_MAX       = 32'sh7FFF_FFFF;
    localparam amp_t                  A_MIN       = 32'sh8000_0000;
    localparam coef_t                 C_ONE       = 32'sh4000_0000;
    localparam coef_t                 C_NEG_ONE   = 32'shC000_0000;
    localparam coef_t                 C_HALF_ROOT = 32'sh2D41_3CCD;

    logic                      clk           = 1'b0;
    logic                      rst_n         = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic [IN_DATA_BITS-1:0]   s_axis_tdata  = '0;
    logic                      m_axis_tready = 1'b0;
    logic                      cfg_we        = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index     = REG_X_MASK;
    logic [COEF_BITS-1:0]      cfg_data      = '0;
    wire                       s_axis_tready;
    wire                       m_axis_tvalid;
    // index_j, new_i_re, new_i_im, new_j_re, new_j_im
    wire [OUT_DATA_BITS-1:0]   m_axis_tdata;
    // pair_duplicate
    wire [0:0]                 m_axis_tuser;

    int  mismatches;
    int  outstanding;
    int  idle_pct    = 0;
    int  stall_pct   = 0;
    bit  hold_toggle = 1'b0;
    int  cycles      = 0;

    pauli_rotation_pair_kernel u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    pprk_pair_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold-off on each toggle
    initial
    begin
        bit seen_toggle;
        seen_toggle = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_toggle != seen_toggle)
            begin
                seen_toggle = hold_toggle;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic amp_t pick_amp();
        case ($urandom_range(9))
            0:       return A_MAX;
            1:       return A_MIN;
            2:       return '0;
            3:       return -1;
            4:       return C_ONE;
            5:       return C_NEG_ONE;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [INDEX_BITS-1:0] pick_index();
        case ($urandom_range(7))
            0:       return '0;
            1:       return ALL_ONES;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [INDEX_BITS-1:0] pick_mask();
        case ($urandom_range(4))
            0:       return '0;
            1:       return ALL_ONES;
            2:       return 32'h1 << $urandom_range(INDEX_BITS - 1);
            default: return $urandom;
        endcase
    endfunction

    function automatic coef_t pick_coef();
        case ($urandom_range(4))
            0:       return C_ONE;
            1:       return C_NEG_ONE;
            2:       return '0;
            default: return coef_t'($urandom_range(32'h8000_0000)) - C_ONE;
        endcase
    endfunction

    // Offer one request, with random gaps ahead of it, and hold until accepted
    task automatic send_pair(logic [INDEX_BITS-1:0] idx, amp_t ar, amp_t ai,
                             amp_t br, amp_t bi);
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {bi, br, ai, ar, idx};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Drop valid and wait until every predicted result has come out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [COEF_BITS-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic apply_setting(logic [INDEX_BITS-1:0] xm, logic [INDEX_BITS-1:0] zm,
                                 coef_t c, coef_t s);
        wait_drained();
        write_reg(REG_X_MASK, xm);
        write_reg(REG_Z_MASK, zm);
        write_reg(REG_COS_THETA, c);
        write_reg(REG_SIN_THETA, s);
        cfg_we <= 1'b0;
    endtask

    task automatic run_pairs(int count);
        repeat (count)
            send_pair(pick_index(), pick_amp(), pick_amp(), pick_amp(), pick_amp());
    endtask

    task automatic run_directed();
        // reset coefficients: identity, pair partner is the index itself
        send_pair('0, A_MAX, A_MAX, A_MAX, A_MAX);
        send_pair(ALL_ONES, A_MIN, A_MIN, A_MIN, A_MIN);
        send_pair(32'h5A5A_5A5A, A_MAX, A_MIN, '0, -1);
        // full X and Z masks with extreme coefficients: saturate both ways
        apply_setting(ALL_ONES, ALL_ONES, C_NEG_ONE, C_ONE);
        send_pair('0, A_MIN, A_MIN, A_MAX, A_MAX);
        send_pair(ALL_ONES, A_MAX, A_MIN, A_MIN, A_MAX);
        send_pair(32'h0000_0001, A_MIN, A_MAX, A_MIN, A_MAX);
        send_pair(32'h8000_0000, A_MAX, A_MAX, A_MIN, A_MIN);
        // single Y factor: odd quarter turns, both pair orders
        apply_setting(32'h1, 32'h3, '0, C_NEG_ONE);
        for (int n = 0; n < 4; n++)
            send_pair(n, pick_amp(), pick_amp(), pick_amp(), pick_amp());
        // X on the top qubit, Z below: even quarter turns
        apply_setting(32'h8000_0000, 32'h0000_00F0, C_HALF_ROOT, C_HALF_ROOT);
        send_pair('0, C_ONE, C_NEG_ONE, C_HALF_ROOT, -1);
        send_pair(32'h0000_0010, A_MAX, A_MAX, A_MIN, A_MIN);
        send_pair(32'h0000_0030, A_MIN, A_MAX, C_ONE, C_ONE);
        send_pair(32'h8000_0070, pick_amp(), pick_amp(), pick_amp(), pick_amp());
        send_pair(32'h8000_00F0, A_MIN, A_MIN, A_MIN, A_MIN);
        send_pair(pick_index(), pick_amp(), pick_amp(), pick_amp(), pick_amp());
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        // random phases, each under its own pattern of gaps and stalls
        for (int mode = 0; mode < 4; mode++)
        begin
            case (mode)
                0:       begin idle_pct = 0;  stall_pct <= 0;  end
                1:       begin idle_pct = 49; stall_pct <= 0;  end
                2:       begin idle_pct = 0;  stall_pct <= 49; end
                default: begin idle_pct = 33; stall_pct <= 33; end
            endcase
            for (int k = 0; k < 3; k++)
            begin
                if (k == 0 && mode == 0)
                    apply_setting(ALL_ONES, ALL_ONES, C_NEG_ONE, C_NEG_ONE);
                else if (k == 0 && mode == 1)
                    apply_setting('0, ALL_ONES, C_ONE, C_ONE);
                else
                    apply_setting(pick_mask(), pick_mask(), pick_coef(), pick_coef());
                run_pairs(SEGMENT_REQS);
            end
        end

        // hold the result side off while requests keep coming
        idle_pct = 0;
        stall_pct <= 0;
        apply_setting(pick_mask(), pick_mask(), pick_coef(), pick_coef());
        hold_toggle <= ~hold_toggle;
        run_pairs(PRESSURE_REQS);

        wait_drained();
        if (mismatches == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
